// ----- src/vfv_pkg.sv -----
// Package for the voxel face visibility query block: grid sizes, field widths,
// operation codes, queue item type and the block id class lookup.
// No dependencies.
package vfv_pkg;

  localparam int unsigned GRID_X = 16;
  localparam int unsigned GRID_Z = 16;
  localparam int unsigned GRID_Y = 128;

  localparam int unsigned XW = 4;
  localparam int unsigned ZW = 4;
  localparam int unsigned YW = 7;
  localparam int unsigned IDW = 8;

  localparam int unsigned CELLS = GRID_X * GRID_Z * GRID_Y;
  localparam int unsigned AW = $clog2(CELLS);

  // class bits per voxel
  localparam int unsigned CLSW = 2;
  localparam int unsigned CLS_DRAW = 0;
  localparam int unsigned CLS_OPAQUE = 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPW = $clog2(QUEUE_DEPTH);

  // one classified item as it sits in the queue
  typedef struct packed {
    logic            op;
    logic [XW-1:0]   x;
    logic [ZW-1:0]   z;
    logic [YW-1:0]   y;
    logic [CLSW-1:0] cls;
    logic            in_grid;
  } cmd_t;

  function automatic logic [CLSW-1:0] id_class(input logic [IDW-1:0] id);
    logic draw;
    logic opaque;
    draw = 1'b1;
    opaque = 1'b1;
    case (id)
      8'd0, 8'd6, 8'd20, 8'd37, 8'd38, 8'd39, 8'd40, 8'd53, 8'd55, 8'd59,
      8'd63, 8'd64, 8'd65, 8'd68, 8'd69, 8'd71, 8'd77, 8'd85, 8'd90: begin
        draw = 1'b0;
        opaque = 1'b0;
      end
      8'd8, 8'd9, 8'd17, 8'd18, 8'd50, 8'd52, 8'd66, 8'd75, 8'd76, 8'd78,
      8'd79, 8'd80, 8'd83: begin
        opaque = 1'b0;
      end
      default: begin
        draw = 1'b1;
        opaque = 1'b1;
      end
    endcase
    id_class = {opaque, draw};
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                               input logic [ZW-1:0] z,
                                               input logic [YW-1:0] y);
    logic [AW-1:0] col;
    col = AW'(x) * AW'(GRID_Z) + AW'(z);
    cell_addr = col * AW'(GRID_Y) + AW'(y);
  endfunction

endpackage

// ----- src/vfv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vfv_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/vfv_front.sv -----
// Front end: accepts items, classifies the block id and checks the grid bounds.
// Depends on vfv_pkg.
module vfv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  logic [3:0]          in_coord_x,
  input  logic [3:0]          in_coord_z,
  input  logic [6:0]          in_coord_y,
  input  logic [7:0]          in_block_id,
  output logic                push,
  output vfv_pkg::cmd_t       push_cmd,
  input  logic                q_full
);
  import vfv_pkg::*;

  logic fr_valid_r, fr_valid_r_nxt;
  cmd_t fr_cmd_r, fr_cmd_r_nxt;
  logic accept;

  assign in_stall = fr_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = fr_valid_r && !q_full;
  assign push_cmd = fr_cmd_r;

  always_comb begin
    fr_valid_r_nxt = accept || (fr_valid_r && q_full);
    fr_cmd_r_nxt   = fr_cmd_r;
    if (accept) begin
      fr_cmd_r_nxt.op      = in_operation;
      fr_cmd_r_nxt.x       = in_coord_x;
      fr_cmd_r_nxt.z       = in_coord_z;
      fr_cmd_r_nxt.y       = in_coord_y;
      fr_cmd_r_nxt.cls     = id_class(in_block_id);
      fr_cmd_r_nxt.in_grid = (32'(in_coord_x) < GRID_X) && (32'(in_coord_z) < GRID_Z) &&
                             (32'(in_coord_y) < GRID_Y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_r_nxt;
    end
    fr_cmd_r <= fr_cmd_r_nxt;
  end

endmodule

// ----- src/vfv_queue.sv -----
// Short FIFO of classified items between front and back end.
// Depends on vfv_pkg.
module vfv_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vfv_pkg::cmd_t push_cmd,
  output logic          q_full,
  input  logic          pop,
  output logic          q_not_empty,
  output vfv_pkg::cmd_t head
);
  import vfv_pkg::*;

  cmd_t           slot_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_r_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_r_nxt;
  logic [QPW:0]   count_r, count_r_nxt;
  logic           do_pop;

  assign q_full      = (count_r == (QPW+1)'(QUEUE_DEPTH));
  assign q_not_empty = (count_r != '0);
  assign head        = slot_r[rd_ptr_r];
  assign do_pop      = pop && q_not_empty;

  always_comb begin
    wr_ptr_r_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_r_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_r_nxt  = count_r;
    if (push && !do_pop) begin
      count_r_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_r_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r_nxt;
      rd_ptr_r <= rd_ptr_r_nxt;
      count_r  <= count_r_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- src/vfv_back.sv -----
// Back end: applies writes to the class store and walks a query through the
// voxel and its six neighbors, one store read per cycle. Depends on vfv_pkg, vfv_ram.
module vfv_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  vfv_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_is_visible
);
  import vfv_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_LAST = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    STEP_CTR = 3'd0,
    STEP_YM  = 3'd1,
    STEP_YP  = 3'd2,
    STEP_ZM  = 3'd3,
    STEP_ZP  = 3'd4,
    STEP_XM  = 3'd5,
    STEP_XP  = 3'd6
  } step_t;

  state_t        state_r, state_r_nxt;
  step_t         step_r, step_r_nxt;
  step_t         step_d_r, step_d_r_nxt;
  logic [XW-1:0] x_r, x_r_nxt;
  logic [ZW-1:0] z_r, z_r_nxt;
  logic [YW-1:0] y_r, y_r_nxt;
  logic          in_grid_r, in_grid_r_nxt;
  logic          valid_d_r, valid_d_r_nxt;
  logic          ok_d_r, ok_d_r_nxt;
  logic          draw_r, draw_r_nxt;
  logic          open_r, open_r_nxt;
  logic          out_valid_r, out_valid_r_nxt;
  logic          vis_r, vis_r_nxt;

  logic            ram_wr_en;
  logic [AW-1:0]   ram_wr_addr;
  logic            ram_rd_en;
  logic [AW-1:0]   ram_rd_addr;
  logic [CLSW-1:0] ram_rd_data;

  logic          nbr_ok;
  logic [XW-1:0] nx;
  logic [ZW-1:0] nz;
  logic [YW-1:0] ny;
  logic          out_free;

  vfv_ram #(.WIDTH(CLSW), .DEPTH(CELLS)) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (head.cls),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign ram_wr_addr = cell_addr(head.x, head.z, head.y);
  assign out_free    = !out_valid_r || !out_stall;

  // neighbor coordinates and in-grid check for the current step
  always_comb begin
    nx = x_r;
    nz = z_r;
    ny = y_r;
    nbr_ok = 1'b0;
    case (step_r)
      STEP_CTR: nbr_ok = in_grid_r;
      STEP_YM: begin
        ny = y_r - 1'b1;
        nbr_ok = in_grid_r && (y_r != '0);
      end
      STEP_YP: begin
        ny = y_r + 1'b1;
        nbr_ok = in_grid_r && (32'(y_r) + 32'd1 < GRID_Y);
      end
      STEP_ZM: begin
        nz = z_r - 1'b1;
        nbr_ok = in_grid_r && (z_r != '0);
      end
      STEP_ZP: begin
        nz = z_r + 1'b1;
        nbr_ok = in_grid_r && (32'(z_r) + 32'd1 < GRID_Z);
      end
      STEP_XM: begin
        nx = x_r - 1'b1;
        nbr_ok = in_grid_r && (x_r != '0);
      end
      STEP_XP: begin
        nx = x_r + 1'b1;
        nbr_ok = in_grid_r && (32'(x_r) + 32'd1 < GRID_X);
      end
      default: nbr_ok = 1'b0;
    endcase
    ram_rd_addr = nbr_ok ? cell_addr(nx, nz, ny) : '0;
  end

  // fold returning store data into the drawable / open flags
  always_comb begin
    draw_r_nxt = draw_r;
    open_r_nxt = open_r;
    if (valid_d_r) begin
      if (step_d_r == STEP_CTR) begin
        draw_r_nxt = ok_d_r && ram_rd_data[CLS_DRAW];
        open_r_nxt = 1'b0;
      end else if (ok_d_r && !ram_rd_data[CLS_OPAQUE]) begin
        open_r_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    state_r_nxt     = state_r;
    step_r_nxt      = step_r;
    x_r_nxt         = x_r;
    z_r_nxt         = z_r;
    y_r_nxt         = y_r;
    in_grid_r_nxt   = in_grid_r;
    pop             = 1'b0;
    ram_wr_en       = 1'b0;
    ram_rd_en       = 1'b0;
    valid_d_r_nxt   = 1'b0;
    step_d_r_nxt    = step_d_r;
    ok_d_r_nxt      = ok_d_r;
    vis_r_nxt       = vis_r;
    out_valid_r_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          pop = 1'b1;
          if (head.op == OP_WRITE) begin
            ram_wr_en = head.in_grid;
          end else begin
            x_r_nxt       = head.x;
            z_r_nxt       = head.z;
            y_r_nxt       = head.y;
            in_grid_r_nxt = head.in_grid;
            step_r_nxt    = STEP_CTR;
            state_r_nxt   = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        ram_rd_en     = 1'b1;
        valid_d_r_nxt = 1'b1;
        step_d_r_nxt  = step_r;
        ok_d_r_nxt    = nbr_ok;
        if (step_r == STEP_XP) begin
          state_r_nxt = ST_LAST;
        end else begin
          step_r_nxt = step_t'(step_r + 3'd1);
        end
      end
      ST_LAST: begin
        // read data holds while the result waits for the output register
        if (out_free) begin
          out_valid_r_nxt = 1'b1;
          vis_r_nxt       = draw_r_nxt && open_r_nxt;
          state_r_nxt     = ST_IDLE;
        end
      end
      default: state_r_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_d_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_r_nxt;
      valid_d_r   <= valid_d_r_nxt;
      out_valid_r <= out_valid_r_nxt;
    end
    step_r    <= step_r_nxt;
    step_d_r  <= step_d_r_nxt;
    x_r       <= x_r_nxt;
    z_r       <= z_r_nxt;
    y_r       <= y_r_nxt;
    in_grid_r <= in_grid_r_nxt;
    ok_d_r    <= ok_d_r_nxt;
    draw_r    <= draw_r_nxt;
    open_r    <= open_r_nxt;
    vis_r     <= vis_r_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_is_visible = vis_r;

  a_tag_follows_run: assert property (@(posedge clk) disable iff (!rst_n)
    valid_d_r |-> $past(state_r == ST_RUN))
    else $error("read tag without a read cycle");

  a_last_has_final_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_LAST) |-> valid_d_r && (step_d_r == STEP_XP))
    else $error("final neighbor read missing on entry to last state");

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == ST_IDLE))
    else $error("store write during a query walk");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LAST))
    else $error("result loaded outside last state");

endmodule

// ----- src/voxel_face_visibility_query_top.sv -----
// Voxel face visibility query, top level. Depends on vfv_pkg, vfv_front, vfv_queue, vfv_back.
// Write item: popped and written in the back end's idle state, so writes stream at one per
// cycle while no query walk holds the back end. Query item: popped, then 7 reads of the
// single class-store read port, then the result is loaded into the output register.
// Reset (rst_n low, synchronous) clears queue, sequencer and output valid; the class
// store itself is not cleared and holds undefined data until written.
module voxel_face_visibility_query_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [3:0] in_coord_x,
  input  logic [3:0] in_coord_z,
  input  logic [6:0] in_coord_y,
  input  logic [7:0] in_block_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_visible
);
  import vfv_pkg::*;

  // front -> queue
  logic push;
  cmd_t push_cmd;
  logic q_full;

  // queue -> back
  logic pop;
  logic q_not_empty;
  cmd_t head;

  // Front: registers each item, looks up its class bits and bounds flag,
  // and pushes it into the queue. Stalls only when the queue is full.
  vfv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_coord_x   (in_coord_x),
    .in_coord_z   (in_coord_z),
    .in_coord_y   (in_coord_y),
    .in_block_id  (in_block_id),
    .push         (push),
    .push_cmd     (push_cmd),
    .q_full       (q_full)
  );

  // Four-entry queue decouples classification from store access, so the
  // front keeps taking items while a query walks its neighbors.
  vfv_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_cmd    (push_cmd),
    .q_full      (q_full),
    .pop         (pop),
    .q_not_empty (q_not_empty),
    .head        (head)
  );

  // Back: owns the class store. Items run strictly in order, so a query
  // always sees every earlier write. The result sits in an output register.
  vfv_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_visible (out_is_visible)
  );

endmodule

// ----- test/voxel_face_visibility_query_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for voxel_face_visibility_query_top: voxel writes and visibility queries,
// each answer predicted from a local copy of the voxel class grid and checked in order.
// Depends on vfv_pkg and the RTL under src/.
module voxel_face_visibility_query_top_tb;
  import vfv_pkg::*;

  localparam int unsigned IDLE_PCT = 7;
  localparam int unsigned DRAIN_CYCLES = 20;     // room left after the last answer for stray results
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  // one predicted query answer, with its coordinates for the log
  typedef struct {
    logic [XW-1:0] x;
    logic [ZW-1:0] z;
    logic [YW-1:0] y;
    logic          is_visible;
  } vis_answer_t;

  // a voxel whose own entry and every in-grid neighbor entry have been written
  typedef struct {
    int x;
    int z;
    int y;
  } site_t;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  logic           in_operation;
  logic [XW-1:0]  in_coord_x;
  logic [ZW-1:0]  in_coord_z;
  logic [YW-1:0]  in_coord_y;
  logic [IDW-1:0] in_block_id;
  logic           out_valid;
  logic           out_stall;
  logic           out_is_visible;

  // local copy of the class grid; written[] marks entries that hold real data
  logic [CLSW-1:0] class_grid [CELLS];
  bit              written [CELLS];

  vis_answer_t pending_visibility [$];
  vis_answer_t head;
  site_t       sites [$];

  bit          idle_en = 1'b1;
  int unsigned mismatches = 0;
  int unsigned n_writes = 0;
  int unsigned n_checked = 0;
  int unsigned n_visible = 0;
  int unsigned quiet_cycles = 0;

  voxel_face_visibility_query_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_coord_x     (in_coord_x),
    .in_coord_z     (in_coord_z),
    .in_coord_y     (in_coord_y),
    .in_block_id    (in_block_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_visible (out_is_visible)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned voxel_index(input int x, input int z, input int y);
    return (x * GRID_Z + z) * GRID_Y + y;
  endfunction

  function automatic bit on_grid(input int x, input int z, input int y);
    return x >= 0 && x < int'(GRID_X) && z >= 0 && z < int'(GRID_Z) &&
           y >= 0 && y < int'(GRID_Y);
  endfunction

  // face neighbor k of a voxel: -x, +x, -z, +z, -y, +y
  function automatic void neighbor_of(input int k, input int x, input int z, input int y,
                                      output int nx, output int nz, output int ny);
    nx = x;
    nz = z;
    ny = y;
    case (k)
      0:       nx = x - 1;
      1:       nx = x + 1;
      2:       nz = z - 1;
      3:       nz = z + 1;
      4:       ny = y - 1;
      default: ny = y + 1;
    endcase
  endfunction

  // class bits of a block id: air, plants, torches and the like are neither
  // drawable nor opaque; water, glass, leaves etc. are drawable but see-through
  function automatic logic [CLSW-1:0] class_of_id(input logic [IDW-1:0] id);
    logic [CLSW-1:0] cls;
    cls = '1;
    case (id)
      0, 6, 20, 37, 38, 39, 40, 53, 55, 59, 63, 64, 65, 68, 69, 71, 77, 85, 90:
        cls[CLS_DRAW] = 1'b0;
      default: ;
    endcase
    case (id)
      0, 6, 8, 9, 17, 18, 20, 37, 38, 39, 40, 50, 52, 53, 55, 59, 63, 64, 65, 66,
      68, 69, 71, 75, 76, 77, 78, 79, 80, 83, 85, 90:
        cls[CLS_OPAQUE] = 1'b0;
      default: ;
    endcase
    return cls;
  endfunction

  // drawable and at least one in-grid face neighbor that light gets through
  function automatic bit predict_visibility(input int x, input int z, input int y);
    int nx, nz, ny;
    bit open_face;
    open_face = 1'b0;
    if (!class_grid[voxel_index(x, z, y)][CLS_DRAW]) return 1'b0;
    for (int k = 0; k < 6; k++) begin
      neighbor_of(k, x, z, y, nx, nz, ny);
      if (on_grid(nx, nz, ny) && !class_grid[voxel_index(nx, nz, ny)][CLS_OPAQUE])
        open_face = 1'b1;
    end
    return open_face;
  endfunction

  // a query may only touch entries that have been written
  function automatic bit fully_written(input int x, input int z, input int y);
    int nx, nz, ny;
    if (!written[voxel_index(x, z, y)]) return 1'b0;
    for (int k = 0; k < 6; k++) begin
      neighbor_of(k, x, z, y, nx, nz, ny);
      if (on_grid(nx, nz, ny) && !written[voxel_index(nx, nz, ny)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Drives one item at the falling edge and holds it until accepted. valid gets
  // at most one assignment per falling edge, so back-to-back items keep it high.
  task automatic send_item(input logic op, input int x, input int z, input int y,
                           input logic [IDW-1:0] id);
    vis_answer_t ans;
    int unsigned idx;
    @(negedge clk);
    while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_coord_x   <= XW'(x);
    in_coord_z   <= ZW'(z);
    in_coord_y   <= YW'(y);
    in_block_id  <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge: update the grid copy or queue the answer
    idx = voxel_index(x, z, y);
    if (op == OP_WRITE) begin
      class_grid[idx] = class_of_id(id);
      written[idx] = 1'b1;
      n_writes++;
    end else begin
      ans.x = XW'(x);
      ans.z = ZW'(z);
      ans.y = YW'(y);
      ans.is_visible = predict_visibility(x, z, y);
      pending_visibility.push_back(ans);
      sites.push_back('{x, z, y});
    end
  endtask

  // edges of the grid get a quarter of the picks
  function automatic int pick_coord(input int top);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  // low ids hold all the see-through and non-drawable classes
  function automatic logic [IDW-1:0] pick_id(input bit mostly_opaque);
    if (mostly_opaque && $urandom_range(0, 99) < 85) return IDW'($urandom_range(128, 255));
    if ($urandom_range(0, 1) == 1) return IDW'($urandom_range(0, 95));
    return IDW'($urandom);
  endfunction

  // Writes a voxel, then all its in-grid neighbors from a random starting face, then queries it.
  // Half the sites grow out of an earlier one so neighborhoods overlap and
  // neighbors of the new site become queryable too.
  task automatic write_and_query_site(input bit mostly_opaque);
    site_t base;
    int cx, cz, cy, nx, nz, ny, first;
    if (sites.size() != 0 && $urandom_range(0, 1) == 1) begin
      base = sites[$urandom_range(0, sites.size() - 1)];
      neighbor_of($urandom_range(0, 5), base.x, base.z, base.y, cx, cz, cy);
      if (!on_grid(cx, cz, cy)) begin
        cx = base.x;
        cz = base.z;
        cy = base.y;
      end
    end else begin
      cx = pick_coord(GRID_X - 1);
      cz = pick_coord(GRID_Z - 1);
      cy = pick_coord(GRID_Y - 1);
    end
    send_item(OP_WRITE, cx, cz, cy, pick_id(1'b0));
    first = $urandom_range(0, 5);
    for (int k = 0; k < 6; k++) begin
      neighbor_of((first + k) % 6, cx, cz, cy, nx, nz, ny);
      if (on_grid(nx, nz, ny)) send_item(OP_WRITE, nx, nz, ny, pick_id(mostly_opaque));
    end
    send_item(OP_QUERY, cx, cz, cy, IDW'($urandom));
    neighbor_of($urandom_range(0, 5), cx, cz, cy, nx, nz, ny);
    if (on_grid(nx, nz, ny) && fully_written(nx, nz, ny))
      send_item(OP_QUERY, nx, nz, ny, IDW'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Low corner: three faces off the grid. All in-grid faces covered means hidden;
  // opening the top face makes it visible.
  task automatic test_low_corner();
    send_item(OP_WRITE, 0, 0, 0, 8'd255);
    send_item(OP_WRITE, 1, 0, 0, 8'd1);
    send_item(OP_WRITE, 0, 1, 0, 8'd2);
    send_item(OP_WRITE, 0, 0, 1, 8'd3);
    send_item(OP_QUERY, 0, 0, 0, 8'd0);
    send_item(OP_WRITE, 0, 0, 1, 8'd0);
    send_item(OP_QUERY, 0, 0, 0, 8'd255);
  endtask

  // High corner: an air voxel next to water is not drawn; a see-through but
  // drawable block there is; it goes hidden again once the water is replaced.
  task automatic test_high_corner();
    send_item(OP_WRITE, 15, 15, 127, 8'd0);
    send_item(OP_WRITE, 14, 15, 127, 8'd8);
    send_item(OP_WRITE, 15, 14, 127, 8'd1);
    send_item(OP_WRITE, 15, 15, 126, 8'd1);
    send_item(OP_QUERY, 15, 15, 127, 8'd255);
    send_item(OP_WRITE, 15, 15, 127, 8'd9);
    send_item(OP_QUERY, 15, 15, 127, 8'd0);
    send_item(OP_WRITE, 14, 15, 127, 8'd4);
    send_item(OP_QUERY, 15, 15, 127, 8'd170);
  endtask

  // Well-formed neighborhoods with random ids, idling on both sides.
  task automatic test_random_sites();
    repeat (55) write_and_query_site($urandom_range(0, 1) == 1);
  endtask

  // No idling on either side: writes stream and queries pile up in the queue.
  task automatic test_back_to_back();
    site_t s;
    idle_en = 1'b0;
    repeat (12) write_and_query_site($urandom_range(0, 3) == 0);
    repeat (16) begin
      s = sites[$urandom_range(0, sites.size() - 1)];
      send_item(OP_QUERY, s.x, s.z, s.y, IDW'($urandom));
    end
    idle_en = 1'b1;
  endtask

  // Noise: stray writes anywhere (overwriting known sites too) mixed with
  // queries of sites and of any voxel that happens to be fully written.
  task automatic test_random_mix();
    site_t s;
    int x, z, y;
    repeat (140) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          s = sites[$urandom_range(0, sites.size() - 1)];
          send_item(OP_QUERY, s.x, s.z, s.y, IDW'($urandom));
        end
        2: send_item(OP_WRITE, $urandom_range(0, GRID_X - 1), $urandom_range(0, GRID_Z - 1),
                     $urandom_range(0, GRID_Y - 1), pick_id(1'b0));
        default: begin
          x = pick_coord(GRID_X - 1);
          z = pick_coord(GRID_Z - 1);
          y = pick_coord(GRID_Y - 1);
          if (fully_written(x, z, y)) send_item(OP_QUERY, x, z, y, IDW'($urandom));
          else send_item(OP_WRITE, x, z, y, pick_id(1'b0));
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result stall, checking and watchdog
  // ---------------------------------------------------------------------------

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= idle_en && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $realtime, what);
  endfunction

  // Results come back in query order, so the oldest answer is the one to match.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_visibility.size() == 0) begin
        note_mismatch($sformatf("result is_visible=%0b with no query outstanding",
                                out_is_visible));
      end else begin
        head = pending_visibility.pop_front();
        n_checked++;
        if (out_is_visible !== head.is_visible)
          note_mismatch($sformatf("query (x=%0d z=%0d y=%0d): is_visible expected %0b got %0b",
                                  head.x, head.z, head.y, head.is_visible, out_is_visible));
        else if (head.is_visible)
          n_visible++;
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d answers outstanding",
               WATCHDOG_LIMIT, pending_visibility.size());
      $display("voxel_face_visibility_query_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_WRITE;
    in_coord_x   <= '0;
    in_coord_z   <= '0;
    in_coord_y   <= '0;
    in_block_id  <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_low_corner();
    test_high_corner();
    test_random_sites();
    test_back_to_back();
    test_random_mix();

    @(negedge clk);
    in_valid <= 1'b0;
    // drain, then leave room for any result nobody asked for
    while (pending_visibility.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d voxel writes and %0d checked queries (%0d visible),",
             n_writes, n_checked, n_visible);
    $display("grid corners and edges, overlapping neighborhoods and unstalled bursts");
    if (mismatches == 0) begin
      $display("voxel_face_visibility_query_top: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("voxel_face_visibility_query_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/vfv_pkg.sv
src/vfv_ram.sv
src/vfv_front.sv
src/vfv_queue.sv
src/vfv_back.sv
src/voxel_face_visibility_query_top.sv
test/voxel_face_visibility_query_top_tb.sv
